// ===== rtl/fat_pkg.sv =====
// Shared types and constants for the fault acknowledge table.
`default_nettype none
package fat_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int CODE_W       = 16;
    localparam int KIND_W       = 2;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_CNT_W    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUBLISH = 2'd0,
        KIND_ACK_ONE = 2'd1,
        KIND_ACK_ALL = 2'd2,
        KIND_LOOKUP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK            = 2'd0,
        STAT_INVALID       = 2'd1,
        STAT_NOT_FOUND     = 2'd2,
        STAT_NOT_AVAILABLE = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic rot;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic need_commit;
        logic rot_done;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/fat_ctrl.sv =====
// Sequencer for the fault acknowledge table: accept, execute, merge, commit.
`default_nettype none
module fat_ctrl
    import fat_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_out_ready,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_ROT  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   slot_free;

    assign slot_free   = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.need_commit) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_ROT;
                end else if (slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ROT: begin
                if (i_sts.rot_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rot = 1'b1;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if ((o_cmd.exec && !i_sts.need_commit) || o_cmd.fin) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fat_dpath.sv =====
// Live and staged fault tables with per-entry comparators and result register.
`default_nettype none
module fat_dpath
    import fat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire [KIND_W-1:0]       i_kind,
    input  wire [CODE_W-1:0]       i_code,
    input  wire                    i_eack,
    input  wire                    i_pres,
    input  wire                    i_last,
    output wire t_sts              o_sts,
    output logic [OUT_DATA_W-1:0]  o_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_kind             r_kind;
    logic [CODE_W-1:0] r_code;
    logic              r_eack, r_pres, r_last;

    logic [CODE_W-1:0] r_lv_code [CAPACITY];
    logic [CAPACITY-1:0] r_lv_ackable, r_lv_acked;
    logic [CNT_W-1:0]  r_lv_cnt, r_lv_ack_cnt;

    logic [CODE_W-1:0] r_sg_code [CAPACITY];
    logic [CAPACITY-1:0] r_sg_ackable, r_sg_acked;
    logic [CNT_W-1:0]  r_sg_cnt, r_sg_ack_cnt;
    logic              r_sg_bad;

    logic [CNT_W-1:0]  r_rot_cnt;
    logic [OUT_DATA_W-1:0] r_out, n_out;

    logic [CAPACITY-1:0] lv_vld, lv_hit, sg_vld, sg_hit, sg_wsel, sg_merge;
    logic code_zero, hit_any, hit_ackable, hit_acked, any_ackable;
    logic sg_full, reject, stage_wr, bad_next, is_pub, out_load;
    logic ack_one_ok, ack_all_ok, stg_clear;
    t_status status;
    logic found;
    logic [CNT_W+OUT_CNT_W-1:0] ack_ext, act_ext;

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            lv_vld[k]   = CNT_W'(k) < r_lv_cnt;
            lv_hit[k]   = lv_vld[k] && (r_lv_code[k] == r_code);
            sg_vld[k]   = CNT_W'(k) < r_sg_cnt;
            sg_hit[k]   = sg_vld[k] && (r_sg_code[k] == r_code);
            sg_wsel[k]  = r_sg_cnt == CNT_W'(k);
            sg_merge[k] = sg_vld[k] && r_sg_ackable[k] && (r_sg_code[k] == r_lv_code[0])
                          && r_lv_ackable[0] && r_lv_acked[0];
        end
    end

    assign code_zero   = (r_code == '0);
    assign hit_any     = |lv_hit;
    assign hit_ackable = |(lv_hit & r_lv_ackable);
    assign hit_acked   = |(lv_hit & r_lv_acked);
    assign any_ackable = |(lv_vld & r_lv_ackable);
    assign sg_full     = (r_sg_cnt == CNT_W'(CAPACITY));
    assign reject      = code_zero || sg_full || (|sg_hit);
    assign is_pub      = (r_kind == KIND_PUBLISH);
    assign stage_wr    = is_pub && r_pres && !reject;
    assign bad_next    = r_sg_bad || (is_pub && r_pres && reject);
    assign ack_one_ok  = (r_kind == KIND_ACK_ONE) && !code_zero && hit_ackable;
    assign ack_all_ok  = (r_kind == KIND_ACK_ALL);
    assign stg_clear   = (i_cmd.exec && is_pub && r_last && bad_next) || i_cmd.fin;

    assign o_sts.need_commit = is_pub && r_last && !bad_next;
    assign o_sts.rot_done    = (r_rot_cnt == r_lv_cnt);

    always_comb begin
        status = STAT_OK;
        found  = 1'b0;
        case (r_kind)
            KIND_PUBLISH: begin
                if (r_last && bad_next) begin
                    status = STAT_INVALID;
                end
            end
            KIND_ACK_ONE: begin
                if (code_zero) begin
                    status = STAT_INVALID;
                end else if (!hit_any) begin
                    status = STAT_NOT_FOUND;
                end else if (!hit_ackable) begin
                    status = STAT_NOT_AVAILABLE;
                end
            end
            KIND_ACK_ALL: begin
                if (!any_ackable) begin
                    status = STAT_NOT_AVAILABLE;
                end
            end
            KIND_LOOKUP: begin
                if (code_zero) begin
                    status = STAT_INVALID;
                end else if (!hit_any) begin
                    status = STAT_NOT_FOUND;
                end else begin
                    found = 1'b1;
                end
            end
            default: begin
                status = STAT_OK;
            end
        endcase
    end

    assign out_load = (i_cmd.exec && !o_sts.need_commit) || i_cmd.fin;

    always_comb begin
        if (i_cmd.fin) begin
            ack_ext = {{OUT_CNT_W{1'b0}}, r_sg_ack_cnt};
            act_ext = {{OUT_CNT_W{1'b0}}, r_sg_cnt};
            n_out   = '0;
            n_out[1:0] = STAT_OK;
        end else begin
            ack_ext = {{OUT_CNT_W{1'b0}}, r_lv_ack_cnt};
            act_ext = {{OUT_CNT_W{1'b0}}, r_lv_cnt};
            n_out   = '0;
            n_out[1:0] = status;
            n_out[2]   = found;
            n_out[3]   = found && hit_ackable;
            n_out[4]   = found && hit_acked;
        end
        n_out[8:5]  = ack_ext[OUT_CNT_W-1:0];
        n_out[12:9] = act_ext[OUT_CNT_W-1:0];
    end

    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_cnt     <= '0;
            r_lv_ack_cnt <= '0;
            r_sg_cnt     <= '0;
            r_sg_ack_cnt <= '0;
            r_sg_bad     <= 1'b0;
            r_rot_cnt    <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_rot_cnt <= '0;
            end else if (i_cmd.rot) begin
                r_rot_cnt <= r_rot_cnt + 1'b1;
            end
            if (stg_clear) begin
                r_sg_cnt     <= '0;
                r_sg_ack_cnt <= '0;
                r_sg_bad     <= 1'b0;
            end else if (i_cmd.exec) begin
                if (stage_wr) begin
                    r_sg_cnt <= r_sg_cnt + 1'b1;
                    if (r_eack) begin
                        r_sg_ack_cnt <= r_sg_ack_cnt + 1'b1;
                    end
                end
                if (is_pub) begin
                    r_sg_bad <= bad_next;
                end
            end
            if (i_cmd.fin) begin
                r_lv_cnt     <= r_sg_cnt;
                r_lv_ack_cnt <= r_sg_ack_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_code <= i_code;
            r_eack <= i_eack;
            r_pres <= i_pres;
            r_last <= i_last;
        end
        if (out_load) begin
            r_out <= n_out;
        end
        for (int k = 0; k < CAPACITY; k++) begin
            if (i_cmd.exec && stage_wr && sg_wsel[k]) begin
                r_sg_code[k]    <= r_code;
                r_sg_ackable[k] <= r_eack;
                r_sg_acked[k]   <= 1'b0;
            end
            if (i_cmd.rot && sg_merge[k]) begin
                r_sg_acked[k] <= 1'b1;
            end
            if (i_cmd.exec && ack_one_ok && lv_hit[k] && r_lv_ackable[k]) begin
                r_lv_acked[k] <= 1'b1;
            end
            if (i_cmd.exec && ack_all_ok && lv_vld[k] && r_lv_ackable[k]) begin
                r_lv_acked[k] <= 1'b1;
            end
            if (i_cmd.rot) begin
                r_lv_code[k]    <= r_lv_code[(k == CAPACITY - 1) ? 0 : k + 1];
                r_lv_ackable[k] <= r_lv_ackable[(k == CAPACITY - 1) ? 0 : k + 1];
                r_lv_acked[k]   <= r_lv_acked[(k == CAPACITY - 1) ? 0 : k + 1];
            end
            if (i_cmd.fin) begin
                r_lv_code[k]    <= r_sg_code[k];
                r_lv_ackable[k] <= r_sg_ackable[k];
                r_lv_acked[k]   <= r_sg_acked[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fault_acknowledge_table_core.sv =====
// Top level of the fault acknowledge table.
//
// Input stream: one transfer per command. tuser carries the kind (publish
// entry, acknowledge one, acknowledge all, look up), tlast closes a
// published list, tdata carries code, acknowledgeable mark and entry flag.
// Output stream: one transfer per command with status, lookup marks and the
// acknowledgeable and active counts after the command.
// Each command passes through accept then execute; the next command is accepted
// only after execute ends. A list close that commits also runs a rotate and a
// final commit step: the old entries of the committed list
// rotate past one compare port, one per cycle, to carry
// acknowledge marks over to matching new entries.
// The result sits in an output register; the next command is accepted while
// it waits. When the receiver stalls, a finished command holds in execute or commit
// and no further command is accepted until the register frees.
// Reset empties the committed and staged lists and drops any pending result.
`default_nettype none
module fault_acknowledge_table_core
    import fat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // code[15:0], entry_acknowledgeable[16], entry_present[17], zero[23:18]
    input  wire [IN_DATA_W-1:0]   i_s_axis_tdata,
    // kind[1:0]
    input  wire [KIND_W-1:0]      i_s_axis_tuser,
    input  wire                   i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // status[1:0], found[2], found_acknowledgeable[3], found_acknowledged[4],
    // acknowledgeable_count[8:5], active_count[12:9], zero[15:13]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cmd cmd;
    t_sts sts;

    fat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    fat_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_kind  (i_s_axis_tuser),
        .i_code  (i_s_axis_tdata[CODE_W-1:0]),
        .i_eack  (i_s_axis_tdata[CODE_W]),
        .i_pres  (i_s_axis_tdata[CODE_W+1]),
        .i_last  (i_s_axis_tlast),
        .o_sts   (sts),
        .o_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/fat_checker.sv =====
// Port-level assertions for the fault acknowledge table, bound to the top level.
`default_nettype none
module fat_checker
    import fat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_axis_tvalid,
    input wire                  o_s_axis_tready,
    input wire                  o_m_axis_tvalid,
    input wire                  i_m_axis_tready,
    input wire [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result appeared one cycle after transfer");

    a_found_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2] || !(o_m_axis_tdata[3] || o_m_axis_tdata[4]))
            && (!o_m_axis_tdata[4] || o_m_axis_tdata[3])
            && (!o_m_axis_tdata[2] || o_m_axis_tdata[1:0] == STAT_OK))
        else $error("inconsistent lookup marks");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CAPACITY < 16) && o_m_axis_tvalid |->
            (o_m_axis_tdata[8:5] <= o_m_axis_tdata[12:9]))
        else $error("acknowledgeable count exceeds active count");

endmodule

bind fault_acknowledge_table_core fat_checker #(.CAPACITY(CAPACITY)) u_fat_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the fault acknowledge table core.
module tb;
    import fat_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int RAND_ITEMS = 1550;
    localparam int POOL_N     = 12;
    localparam int DRAIN      = 40;
    localparam int LIMIT      = 1_000_000;

    typedef struct packed {
        logic [2:0] pad;
        logic [3:0] live_cnt;
        logic [3:0] ack_cnt;
        logic       f_acked;
        logic       f_ackable;
        logic       found;
        t_status    status;
    } t_table_result;

    typedef struct {
        t_kind         kind;
        logic [15:0]   code;
        bit            ack;
        bit            pres;
        bit            last;
        bit            typed;
        t_table_result want;
    } t_cmd_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [KIND_W-1:0]     i_s_axis_tuser;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    fault_acknowledge_table_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [15:0]   act_codes [CAP];
    bit            act_ackable [CAP];
    bit            act_acked [CAP];
    int            act_count = 0;
    logic [15:0]   stg_codes [CAP];
    bit            stg_ackable [CAP];
    int            stg_count = 0;
    bit            stg_bad = 1'b0;

    t_table_result pending_results[$];
    t_cmd_row      dir_rows[$];
    logic [15:0]   code_pool [POOL_N];
    int            err_count = 0;
    int            cycles = 0;
    int            n_sent = 0;
    t_table_result got;
    t_table_result want;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int live_slot(input logic [15:0] c);
        for (int i = 0; i < act_count; i++) begin
            if (act_codes[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic t_table_result table_step(input t_kind k, input logic [15:0] c,
                                                 input bit a, input bit p, input bit l);
        t_table_result r;
        int            slot;
        int            n;
        bit            any;
        logic [15:0]   nc [CAP];
        bit            nk [CAP];
        bit            na [CAP];
        r = '0;
        r.status = STAT_OK;
        case (k)
            KIND_PUBLISH: begin
                if (p) begin
                    if (stg_count >= CAP || c == 16'd0) begin
                        stg_bad = 1'b1;
                    end else begin
                        any = 1'b0;
                        for (int i = 0; i < stg_count; i++) begin
                            if (stg_codes[i] == c) any = 1'b1;
                        end
                        if (any) begin
                            stg_bad = 1'b1;
                        end else begin
                            stg_codes[stg_count]   = c;
                            stg_ackable[stg_count] = a;
                            stg_count++;
                        end
                    end
                end
                if (l) begin
                    if (stg_bad) begin
                        r.status = STAT_INVALID;
                    end else begin
                        for (int i = 0; i < stg_count; i++) begin
                            slot  = live_slot(stg_codes[i]);
                            nc[i] = stg_codes[i];
                            nk[i] = stg_ackable[i];
                            na[i] = stg_ackable[i] && slot >= 0 &&
                                    act_ackable[slot] && act_acked[slot];
                        end
                        for (int i = 0; i < stg_count; i++) begin
                            act_codes[i]   = nc[i];
                            act_ackable[i] = nk[i];
                            act_acked[i]   = na[i];
                        end
                        act_count = stg_count;
                    end
                    stg_count = 0;
                    stg_bad   = 1'b0;
                end
            end
            KIND_ACK_ONE: begin
                slot = live_slot(c);
                if (c == 16'd0) r.status = STAT_INVALID;
                else if (slot < 0) r.status = STAT_NOT_FOUND;
                else if (!act_ackable[slot]) r.status = STAT_NOT_AVAILABLE;
                else act_acked[slot] = 1'b1;
            end
            KIND_ACK_ALL: begin
                any = 1'b0;
                for (int i = 0; i < act_count; i++) begin
                    if (act_ackable[i]) begin
                        act_acked[i] = 1'b1;
                        any = 1'b1;
                    end
                end
                if (!any) r.status = STAT_NOT_AVAILABLE;
            end
            default: begin
                slot = live_slot(c);
                if (c == 16'd0) begin
                    r.status = STAT_INVALID;
                end else if (slot < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.found     = 1'b1;
                    r.f_ackable = act_ackable[slot];
                    r.f_acked   = act_acked[slot];
                end
            end
        endcase
        n = 0;
        for (int i = 0; i < act_count; i++) begin
            if (act_ackable[i]) n++;
        end
        r.ack_cnt  = n[3:0];
        r.live_cnt = act_count[3:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        err_count++;
        if (err_count <= 50) begin
            $display("tb: mismatch in %s: got %0d, expected %0d (cycle %0d)",
                     what, got_v, want_v, cycles);
        end
    endtask

    task automatic add_row(input t_kind k, input logic [15:0] c, input bit a, input bit p,
                           input bit l, input bit typed, input t_status st, input bit f,
                           input bit fk, input bit fa, input int ac, input int n);
        t_cmd_row row;
        row.kind           = k;
        row.code           = c;
        row.ack            = a;
        row.pres           = p;
        row.last           = l;
        row.typed          = typed;
        row.want           = '0;
        row.want.status    = st;
        row.want.found     = f;
        row.want.f_ackable = fk;
        row.want.f_acked   = fa;
        row.want.ack_cnt   = ac[3:0];
        row.want.live_cnt  = n[3:0];
        dir_rows.push_back(row);
    endtask

    // Idle for a random gap (maybe none), present one command, hold it until the transfer, then record the expectation.
    task automatic send(input t_kind k, input logic [15:0] c, input bit a, input bit p,
                        input bit l, input bit typed, input t_table_result w);
        int            gap;
        t_table_result pred;
        gap = ((n_sent % 200) < 25) ? 0 : pick_gap();
        n_sent++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, p, a, c};
        i_s_axis_tuser  <= k;
        i_s_axis_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = table_step(k, c, a, p, l);
        pending_results.push_back(typed ? w : pred);
        @(negedge i_clk);
    endtask

    initial begin : rx_side
        int n;
        int gap;
        n = 0;
        @(negedge i_clk);
        forever begin
            n++;
            gap = ((n % 50) < 8) ? 0 : pick_gap();
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_table_result'(o_m_axis_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", int'(got), 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
                if (got.found !== want.found)
                    report_mismatch("found", int'(got.found), int'(want.found));
                if (got.f_ackable !== want.f_ackable)
                    report_mismatch("found_acknowledgeable", int'(got.f_ackable),
                                    int'(want.f_ackable));
                if (got.f_acked !== want.f_acked)
                    report_mismatch("found_acknowledged", int'(got.f_acked),
                                    int'(want.f_acked));
                if (got.ack_cnt !== want.ack_cnt)
                    report_mismatch("acknowledgeable_count", int'(got.ack_cnt),
                                    int'(want.ack_cnt));
                if (got.live_cnt !== want.live_cnt)
                    report_mismatch("active_count", int'(got.live_cnt), int'(want.live_cnt));
                if (got.pad !== want.pad)
                    report_mismatch("padding", int'(got.pad), int'(want.pad));
            end
        end
    end

    initial begin : stim
        int          r;
        int          len;
        int          s;
        int          lists;
        int          rand_sent;
        bit          closing;
        bit          p;
        bit          l;
        t_kind       k;
        logic [15:0] c;
        t_cmd_row    row;
        lists     = 0;
        rand_sent = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= KIND_PUBLISH;
        i_s_axis_tlast  <= 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(KIND_LOOKUP,  16'h0001, 0, 0, 0, 1, STAT_NOT_FOUND,     0, 0, 0, 0, 0);
        add_row(KIND_ACK_ONE, 16'h0000, 0, 0, 0, 1, STAT_INVALID,       0, 0, 0, 0, 0);
        add_row(KIND_ACK_ALL, 16'h0000, 0, 0, 0, 1, STAT_NOT_AVAILABLE, 0, 0, 0, 0, 0);
        add_row(KIND_LOOKUP,  16'h0000, 0, 0, 0, 1, STAT_INVALID,       0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'hFFFF, 1, 1, 0, 1, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0001, 0, 1, 0, 1, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0000, 0, 0, 1, 1, STAT_OK,            0, 0, 0, 1, 2);
        add_row(KIND_LOOKUP,  16'hFFFF, 0, 0, 0, 1, STAT_OK,            1, 1, 0, 1, 2);
        add_row(KIND_ACK_ONE, 16'h0001, 0, 0, 0, 1, STAT_NOT_AVAILABLE, 0, 0, 0, 1, 2);
        add_row(KIND_ACK_ONE, 16'h1234, 0, 0, 0, 1, STAT_NOT_FOUND,     0, 0, 0, 1, 2);
        add_row(KIND_ACK_ONE, 16'hFFFF, 0, 0, 0, 1, STAT_OK,            0, 0, 0, 1, 2);
        add_row(KIND_PUBLISH, 16'h0000, 0, 0, 0, 1, STAT_OK,            0, 0, 0, 1, 2);
        add_row(KIND_PUBLISH, 16'hFFFF, 1, 1, 0, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0002, 1, 1, 1, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_LOOKUP,  16'hFFFF, 0, 0, 0, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_ACK_ALL, 16'h0000, 0, 0, 0, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0000, 1, 1, 1, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0005, 0, 1, 0, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0005, 1, 1, 1, 0, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_PUBLISH, 16'h0000, 0, 0, 1, 1, STAT_OK,            0, 0, 0, 0, 0);
        add_row(KIND_ACK_ALL, 16'h0000, 0, 0, 0, 1, STAT_NOT_AVAILABLE, 0, 0, 0, 0, 0);
        add_row(KIND_LOOKUP,  16'hFFFF, 0, 0, 0, 1, STAT_NOT_FOUND,     0, 0, 0, 0, 0);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send(row.kind, row.code, row.ack, row.pres, row.last, row.typed, row.want);
        end

        while (rand_sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if (lists % 40 == 0) begin
                    foreach (code_pool[i]) code_pool[i] = 16'($urandom_range(1, 65535));
                    if ($urandom_range(0, 1)) code_pool[0] = 16'hFFFF;
                end
                lists++;
                len = ($urandom_range(0, 99) < 8) ? $urandom_range(CAP + 1, CAP + 2)
                                                  : $urandom_range(0, CAP);
                s = $urandom_range(0, POOL_N - 1);
                closing = (len > 0) && ($urandom_range(0, 99) < 70);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 8) begin
                        send(t_kind'($urandom_range(1, 3)),
                             code_pool[$urandom_range(0, POOL_N - 1)],
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 0, '0);
                        rand_sent++;
                    end
                    c = code_pool[(s + i) % POOL_N];
                    if ($urandom_range(0, 99) < 3) c = 16'h0000;
                    else if (i > 0 && $urandom_range(0, 99) < 3) c = code_pool[s];
                    send(KIND_PUBLISH, c, 1'($urandom_range(0, 1)), 1'b1,
                         closing && (i == len - 1), 0, '0);
                    rand_sent++;
                end
                if (!closing) begin
                    send(KIND_PUBLISH, 16'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b1,
                         0, '0);
                    rand_sent++;
                end
            end else if (r < 88) begin
                r = $urandom_range(0, 99);
                if (r < 70) c = code_pool[$urandom_range(0, POOL_N - 1)];
                else if (r < 88) c = 16'($urandom);
                else if (r < 95) c = 16'h0000;
                else c = 16'hFFFF;
                send(t_kind'($urandom_range(1, 3)), c, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, '0);
                rand_sent++;
            end else begin
                k = t_kind'($urandom_range(0, 3));
                p = 1'($urandom_range(0, 1));
                l = 1'($urandom_range(0, 1));
                send(k, 16'($urandom), 1'($urandom_range(0, 1)), p, l, 0, '0);
                if (!(k == KIND_PUBLISH && !p && !l)) rand_sent++;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
